FILE: sv/ppcbb_pkg.sv
// Package for the PowerPC basic-block leader scan.
// Holds the word types, instruction decode constants and sequencer states.
// No dependencies; every other file of the block but ppcbb_ram imports it.
package ppcbb_pkg;

    localparam int MAX_INSTS_DEF = 1024;
    localparam int LEN_W         = 11;

    localparam logic CMD_FEED  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [5:0] OP_BC = 6'd16;
    localparam logic [5:0] OP_SC = 6'd17;
    localparam logic [5:0] OP_B  = 6'd18;
    localparam logic [5:0] OP_XL = 6'd19;
    localparam logic [5:0] OP_X  = 6'd31;

    localparam logic [9:0] XO_BCLR  = 10'd16;
    localparam logic [9:0] XO_RFI   = 10'd50;
    localparam logic [9:0] XO_MTMSR = 10'd146;
    localparam logic [9:0] XO_BCCTR = 10'd528;

    typedef struct packed {
        logic        cmd;
        logic [31:0] inst_word;
    } in_t;

    typedef struct packed {
        logic [31:0]      block_pc;
        logic [LEN_W-1:0] block_len;
        logic             last_block;
        logic             overflow;
    } out_t;

    typedef struct packed {
        logic        en;
        logic        sub;
        logic [31:0] a;
        logic [31:0] b;
    } alu_req_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_F_PC,
        ST_F_TGT,
        ST_F_OFF,
        ST_F_MARK,
        ST_F_NEXT,
        ST_D_CHECK,
        ST_D_TEST,
        ST_D_DONE
    } state_t;

endpackage

FILE: sv/ppcbb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the leader bitmap; no package dependencies.
module ppcbb_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/ppcbb_alu.sv
// Shared 32-bit add/subtract unit with a registered result.
// Depends on ppcbb_pkg for the request structure.
module ppcbb_alu
    import ppcbb_pkg::*;
(
    input  logic        clk,
    input  alu_req_t    req,
    output logic [31:0] y
);

    logic [31:0] y_reg;

    // The result holds until the next request, so the sequencer may read it late.
    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            y_reg <= req.sub ? (req.a - req.b) : (req.a + req.b);
        end
    end

    assign y = y_reg;

endmodule

FILE: sv/ppcbb_seq.sv
// Sequencer of the leader scan: decodes fed words, drives the shared adder,
// sets and scans the leader bitmap and holds the result register.
// Depends on ppcbb_pkg.
module ppcbb_seq
    import ppcbb_pkg::*;
#(
    parameter int MAX_INSTS = MAX_INSTS_DEF,
    localparam int IDX_W = (MAX_INSTS > 1) ? $clog2(MAX_INSTS) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [31:0]      base,
    input  logic             item_valid,
    output logic             item_stall,
    input  in_t              item,
    output logic             result_valid,
    input  logic             result_stall,
    output out_t             result,
    output alu_req_t         alu_req,
    input  logic [31:0]      alu_y,
    output logic             ram_we,
    output logic [IDX_W-1:0] ram_waddr,
    output logic             ram_wdata,
    output logic [IDX_W-1:0] ram_raddr,
    input  logic             ram_rdata
);

    localparam int CNT_W = $clog2(MAX_INSTS + 1);
    localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_INSTS - 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_INSTS);
    localparam logic [31:0]      OFF_LIM = 32'(MAX_INSTS * 4);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   fed_reg, fed_next;
    logic [CNT_W-1:0]   drain_reg, drain_next;
    logic [CNT_W-1:0]   end_reg, end_next;
    logic               ovf_reg, ovf_next;
    logic [IDX_W-1:0]   clr_reg, clr_next;
    logic [31:0]        inst_reg, inst_next;
    logic               result_valid_reg, result_valid_next;
    out_t               result_reg, result_next;

    logic               accept;
    logic [5:0]         op;
    logic [9:0]         xo;
    logic               is_br;
    logic               ends;
    logic [31:0]        disp;
    logic [CNT_W-1:0]   fed_inc;
    logic [CNT_W-1:0]   end_c;
    logic [CNT_W-1:0]   len_c;
    logic [31:0]        len32;
    logic               is_last;
    logic               can_load;

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;

    // Decode of the held instruction word.
    assign op    = inst_reg[31:26];
    assign xo    = inst_reg[10:1];
    assign is_br = (op == OP_B) || (op == OP_BC);
    assign disp  = (op == OP_B) ? {{6{inst_reg[25]}}, inst_reg[25:2], 2'b00}
                                : {{16{inst_reg[15]}}, inst_reg[15:2], 2'b00};
    assign ends  = is_br || (op == OP_SC)
                 || ((op == OP_XL) && (xo inside {XO_BCLR, XO_BCCTR, XO_RFI}))
                 || ((op == OP_X) && (xo == XO_MTMSR));

    assign fed_inc  = fed_reg + 1'b1;
    assign end_c    = (end_reg > fed_reg) ? fed_reg : end_reg;
    assign is_last  = (end_reg >= fed_reg);
    assign len_c    = end_c - drain_reg;
    assign len32    = 32'(len_c);
    assign can_load = !result_valid_reg || !result_stall;

    assign ram_raddr = end_reg[IDX_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == MAX_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.cmd == CMD_DRAIN)
                    begin
                        state_next = ST_D_CHECK;
                    end
                    else if (fed_reg < MAX_CNT)
                    begin
                        state_next = ST_F_PC;
                    end
                end
            end
            ST_F_PC:    state_next = is_br ? ST_F_TGT : ST_F_NEXT;
            ST_F_TGT:   state_next = ST_F_OFF;
            ST_F_OFF:   state_next = ST_F_MARK;
            ST_F_MARK:  state_next = ST_F_NEXT;
            ST_F_NEXT:  state_next = ST_IDLE;
            ST_D_CHECK: state_next = (end_reg < fed_reg) ? ST_D_TEST : ST_D_DONE;
            ST_D_TEST:  state_next = ram_rdata ? ST_D_DONE : ST_D_CHECK;
            ST_D_DONE:
            begin
                if (can_load)
                begin
                    state_next = is_last ? ST_CLEAR : ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Adder requests and bitmap writes.
    always_comb
    begin
        alu_req   = '0;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
            end
            ST_IDLE:
            begin
                if (accept && (item.cmd == CMD_DRAIN))
                begin
                    alu_req = '{en: 1'b1, sub: 1'b0, a: base, b: 32'(drain_reg) << 2};
                end
            end
            ST_F_PC:
            begin
                if (is_br)
                begin
                    alu_req = '{en: 1'b1, sub: 1'b0, a: base, b: 32'(fed_reg) << 2};
                end
            end
            ST_F_TGT:
            begin
                alu_req = '{en: 1'b1, sub: 1'b0, a: inst_reg[1] ? 32'd0 : alu_y, b: disp};
            end
            ST_F_OFF:
            begin
                alu_req = '{en: 1'b1, sub: 1'b1, a: alu_y, b: base};
            end
            ST_F_MARK:
            begin
                if ((alu_y[1:0] == 2'b00) && (alu_y < OFF_LIM))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = alu_y[IDX_W+1:2];
                    ram_wdata = 1'b1;
                end
            end
            ST_F_NEXT:
            begin
                if (ends && (fed_inc < MAX_CNT))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = fed_inc[IDX_W-1:0];
                    ram_wdata = 1'b1;
                end
            end
            default:
            begin
                alu_req = '0;
            end
        endcase
    end

    // Counters, flags and the result register.
    always_comb
    begin
        fed_next          = fed_reg;
        drain_next        = drain_reg;
        end_next          = end_reg;
        ovf_next          = ovf_reg;
        clr_next          = clr_reg;
        inst_next         = inst_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    inst_next = item.inst_word;
                    if (item.cmd == CMD_DRAIN)
                    begin
                        end_next = drain_reg + 1'b1;
                    end
                    else if (fed_reg >= MAX_CNT)
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            ST_F_NEXT:
            begin
                fed_next = fed_inc;
            end
            ST_D_TEST:
            begin
                if (!ram_rdata)
                begin
                    end_next = end_reg + 1'b1;
                end
            end
            ST_D_DONE:
            begin
                if (can_load)
                begin
                    result_valid_next      = 1'b1;
                    result_next.block_pc   = alu_y;
                    result_next.block_len  = len32[LEN_W-1:0];
                    result_next.last_block = is_last;
                    result_next.overflow   = ovf_reg;
                    if (is_last)
                    begin
                        fed_next   = '0;
                        drain_next = '0;
                        ovf_next   = 1'b0;
                        clr_next   = '0;
                    end
                    else
                    begin
                        drain_next = end_c;
                    end
                end
            end
            default:
            begin
                clr_next = clr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            fed_reg          <= '0;
            drain_reg        <= '0;
            end_reg          <= '0;
            ovf_reg          <= 1'b0;
            clr_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            fed_reg          <= fed_next;
            drain_reg        <= drain_next;
            end_reg          <= end_next;
            ovf_reg          <= ovf_next;
            clr_reg          <= clr_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inst_reg   <= inst_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: sv/ppc_basic_block_leader_scan_top.sv
// Top level of the PowerPC basic-block leader scan.
// Instantiates ppcbb_seq, ppcbb_alu and ppcbb_ram; depends on ppcbb_pkg.
//
// The block takes a function's instruction words one at a time and returns its basic
// blocks in address order. A word with cmd 0 is fed: branches (b, bl, bc) have their
// target worked out and, when it falls inside the function, marked as a leader, and
// any branch, bclr, bcctr, rfi, sc or mtmsr makes the following word a leader. A word
// with cmd 1 asks for the next block record and gives one result word: start address,
// instruction count, a last flag and the overflow flag. The last record clears the scan
// so that the next feed starts a new function. Words fed beyond MAX_INSTS are dropped
// and set the overflow flag. The function's start address is the single configuration
// register, written through cfg_valid/cfg_ready/cfg_data; its low two bits are ignored,
// and it should only be written while the block is idle. All address arithmetic goes
// through one shared 32-bit adder with a registered result, and the leader bitmap is a
// single memory with one read and one write port. A non-branch feed passes through the
// PC and next steps, a branch feed also through the target, offset and mark steps, and
// a dropped feed leaves the block idle; no new word is taken until a feed is done. A
// drain alternates a check and a test step for each bitmap entry it tests; while the
// result register is still full the drain waits in its final step. After reset, and
// after the last record of a function has been loaded, the bitmap is cleared one entry
// per cycle; item_stall is high throughout. The result sits in its own register, so a
// finished record may wait on result_stall while the block goes on taking feed words; a
// further record is held back until that register is free.
module ppc_basic_block_leader_scan_top
    import ppcbb_pkg::*;
#(
    parameter int MAX_INSTS = MAX_INSTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  in_t         item,
    output logic        result_valid,
    input  logic        result_stall,
    output out_t        result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    localparam int IDX_W = (MAX_INSTS > 1) ? $clog2(MAX_INSTS) : 1;

    logic [31:0]      base_reg;
    alu_req_t         alu_req;
    logic [31:0]      alu_y;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic             ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic             ram_rdata;

    // The configuration register is always ready; the base is stored word-aligned.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            base_reg <= {cfg_data[31:2], 2'b00};
        end
    end

    // Sequencer: owns the counters, decode and the result register.
    ppcbb_seq #(
        .MAX_INSTS (MAX_INSTS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .base         (base_reg),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .alu_req      (alu_req),
        .alu_y        (alu_y),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata)
    );

    // The one adder: instruction PC, branch target, offset from base and block PC.
    ppcbb_alu u_alu (
        .clk (clk),
        .req (alu_req),
        .y   (alu_y)
    );

    // Leader bitmap, one bit per instruction slot.
    ppcbb_ram #(
        .WIDTH (1),
        .DEPTH (MAX_INSTS)
    ) u_leader_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

FILE: sv/ppcbb_chk.sv
// Port-level checker for the leader scan top level, with its bind statement.
// Depends on ppcbb_pkg and on ppc_basic_block_leader_scan_top.
module ppcbb_chk
    import ppcbb_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_stall,
    input in_t         item,
    input logic        result_valid,
    input logic        result_stall,
    input out_t        result,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    // A record waiting on result_stall stays put.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result word changed");

    // A drain request always leaves the sequencer busy, with item_stall raised.
    a_drain_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (item.cmd == CMD_DRAIN) |=> item_stall)
        else $error("block accepted a word straight after a drain request");

    // A fresh record is only loaded out of the busy drain step.
    a_result_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_stall))
        else $error("result word appeared while the sequencer was idle");

    // The configuration register never pushes back.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write was held off");

endmodule

bind ppc_basic_block_leader_scan_top ppcbb_chk u_chk (.*);

FILE: sim/testbench.sv
// Self-checking testbench for ppc_basic_block_leader_scan_top.
// Keeps its own copy of the leader scan and checks every block record against it.
// Depends on ppcbb_pkg and the block's RTL only.
`timescale 1ns / 100ps

module testbench;
    import ppcbb_pkg::*;

    localparam int MAX_INSTS = MAX_INSTS_DEF;

    // The run is stopped at this limit, set well past the slowest correct run
    // once every bitmap clear is counted.
    localparam int unsigned CYCLE_LIMIT = 1000000;

    // Cycles to let pass before a register write: a feed gives no result, so
    // the block may still be busy, and the bitmap clear after the last record
    // of a function may still be running.
    localparam int SETTLE_CYCLES = MAX_INSTS + 64;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    in_t         item = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    out_t        result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;

    // Percentages of cycles in which the sender holds back a word and the
    // receiver stalls the result channel.
    int send_idle = 0;
    int recv_idle = 0;

    int          mismatches = 0;
    int unsigned words_sent = 0;

    // Shadow state of the scan: function start address, leader bitmap,
    // number of words taken, drain position and the overflow flag.
    logic [31:0]          shadow_base = '0;
    bit [MAX_INSTS-1:0]   leader_bits = '0;
    int unsigned          fed_n = 0;
    int unsigned          drain_at = 0;
    bit                   ovf_seen = 1'b0;

    // Block records that the shadow scan says are still to come, oldest first.
    out_t block_q[$];

    ppc_basic_block_leader_scan_top #(
        .MAX_INSTS(MAX_INSTS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always #1 clk = ~clk;

    // The receiver stalls at random, at the rate of the current phase.
    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99) < recv_idle);
    end

    // ------------------------------------------------------------------
    // Shadow scan
    // ------------------------------------------------------------------

    // The low two bits of the start address are ignored by the block.
    function automatic logic [31:0] func_start();
        return {shadow_base[31:2], 2'b00};
    endfunction

    // A target counts as a leader only when it is word aligned and lies
    // within MAX_INSTS words of the start; whether it is inside the function
    // proper is settled at drain time against the number of words fed.
    function automatic void mark_target(logic [31:0] tgt);
        logic [31:0] off;
        off = tgt - func_start();
        if (off[1:0] == 2'b00 && off < MAX_INSTS * 4)
            leader_bits[off >> 2] = 1'b1;
    endfunction

    function automatic void shadow_feed(logic [31:0] w);
        logic [31:0] pc;
        logic [31:0] disp;
        logic [5:0]  op;
        logic [9:0]  xo;
        bit          ends;
        int unsigned idx;
        if (fed_n >= MAX_INSTS)
        begin
            // Beyond capacity the word is dropped.
            ovf_seen = 1'b1;
            return;
        end
        idx  = fed_n;
        pc   = func_start() + idx * 4;
        op   = w[31:26];
        xo   = w[10:1];
        ends = 1'b0;
        case (op)
            OP_B:
            begin
                disp = {{6{w[25]}}, w[25:2], 2'b00};
                mark_target(w[1] ? disp : pc + disp);
                ends = 1'b1;
            end
            OP_BC:
            begin
                disp = {{16{w[15]}}, w[15:2], 2'b00};
                mark_target(w[1] ? disp : pc + disp);
                ends = 1'b1;
            end
            OP_XL:
                ends = (xo == XO_BCLR || xo == XO_BCCTR || xo == XO_RFI);
            OP_SC:
                ends = 1'b1;
            OP_X:
                ends = (xo == XO_MTMSR);
            default:
                ends = 1'b0;
        endcase
        if (ends && idx + 1 < MAX_INSTS)
            leader_bits[idx + 1] = 1'b1;
        fed_n = idx + 1;
    endfunction

    // Works out the next block record; the last record of a function
    // clears the whole scan.
    function automatic out_t shadow_drain();
        int unsigned first;
        int unsigned stop;
        logic [31:0] span_len;
        out_t        rec;
        first = drain_at;
        stop  = first + 1;
        while (stop < fed_n && stop < MAX_INSTS && !leader_bits[stop])
            stop++;
        if (stop > fed_n)
            stop = fed_n;
        span_len       = stop - first;
        rec.block_pc   = func_start() + first * 4;
        rec.block_len  = span_len[LEN_W-1:0];
        rec.last_block = (stop >= fed_n);
        rec.overflow   = ovf_seen;
        if (rec.last_block)
        begin
            leader_bits = '0;
            fed_n       = 0;
            drain_at    = 0;
            ovf_seen    = 1'b0;
        end
        else
        begin
            drain_at = stop;
        end
        return rec;
    endfunction

    // ------------------------------------------------------------------
    // Instruction words
    // ------------------------------------------------------------------

    // A word that neither branches nor ends a block, whatever its other bits.
    function automatic logic [31:0] plain_word();
        logic [31:0] w;
        do
            w = $urandom;
        while (w[31:26] == OP_BC || w[31:26] == OP_SC || w[31:26] == OP_B ||
               w[31:26] == OP_XL || w[31:26] == OP_X);
        return w;
    endfunction

    // A b or bc word, from the next position to be fed, aimed at word tidx of
    // the function. The absolute form only lands inside when the target fits
    // the displacement field; otherwise it simply goes elsewhere.
    function automatic logic [31:0] branch_to(int unsigned tidx, bit cond, bit absolute);
        logic [31:0] tgt;
        logic [31:0] disp;
        logic [31:0] w;
        tgt  = func_start() + tidx * 4;
        disp = absolute ? tgt : tgt - (func_start() + fed_n * 4);
        w    = $urandom;
        if (cond)
        begin
            w[31:26] = OP_BC;
            w[15:2]  = disp[15:2];
        end
        else
        begin
            w[31:26] = OP_B;
            w[25:2]  = disp[25:2];
        end
        w[1] = absolute;
        return w;
    endfunction

    // bclr, bcctr, rfi, sc or mtmsr, with random bits in the other fields.
    function automatic logic [31:0] block_end_word(int kind);
        logic [31:0] w;
        w = $urandom;
        case (kind)
            0:
            begin
                w[31:26] = OP_XL;
                w[10:1]  = XO_BCLR;
            end
            1:
            begin
                w[31:26] = OP_XL;
                w[10:1]  = XO_BCCTR;
            end
            2:
            begin
                w[31:26] = OP_XL;
                w[10:1]  = XO_RFI;
            end
            3:
                w[31:26] = OP_SC;
            default:
            begin
                w[31:26] = OP_X;
                w[10:1]  = XO_MTMSR;
            end
        endcase
        return w;
    endfunction

    // The mix used for random functions: plain code most often, then branches
    // that land in or just beyond the function, block enders, opcodes that
    // share an ender's primary opcode, and raw noise.
    function automatic logic [31:0] random_word(int unsigned span);
        logic [31:0] w;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 45)
            w = plain_word();
        else if (pick < 65)
            w = branch_to($urandom_range(span - 1), $urandom_range(1),
                          $urandom_range(3) == 0);
        else if (pick < 80)
            w = block_end_word($urandom_range(4));
        else if (pick < 88)
        begin
            w = $urandom;
            w[31:26] = $urandom_range(1) ? OP_XL : OP_X;
        end
        else
            w = $urandom;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Sending words
    // ------------------------------------------------------------------

    // Offers one word, with random idle cycles ahead of it, and updates the
    // shadow scan when the word is taken. fn_done tells that the word was a
    // drain that returned the last record of the function. Valid is left high
    // on return, so that a following word goes out without a gap.
    task automatic push_item(input logic cmd, input logic [31:0] w, output bit fn_done);
        out_t rec;
        fn_done = 1'b0;
        while ($urandom_range(99) < send_idle)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= '{cmd: cmd, inst_word: w};
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        words_sent++;
        if (cmd == CMD_FEED)
        begin
            shadow_feed(w);
        end
        else
        begin
            rec = shadow_drain();
            block_q.insert(block_q.size(), rec);
            fn_done = rec.last_block;
        end
    endtask

    task automatic feed(input logic [31:0] w);
        bit fn_done;
        push_item(CMD_FEED, w, fn_done);
    endtask

    // The instruction field of a drain word is ignored, so it carries noise.
    task automatic drain_step(output bit fn_done);
        push_item(CMD_DRAIN, $urandom, fn_done);
    endtask

    task automatic drain_to_end();
        bit fn_done;
        do
            drain_step(fn_done);
        while (!fn_done);
    endtask

    // Holds the sender back until every record the shadow scan predicts has
    // come out. It lowers valid and waits on the clock before its first check,
    // so valid is never lowered and raised again within one time step.
    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (block_q.size() != 0)
            @(posedge clk);
    endtask

    // Writes the start address while the block is idle. A feed has no result
    // to wait for, so the block is given time to finish any feed and any
    // bitmap clear before the write is offered.
    task automatic set_base(input logic [31:0] v);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid   <= 1'b0;
        shadow_base = v;
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Every record taken from the block is held against the oldest one the
    // shadow scan has predicted.
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (block_q.size() == 0)
            begin
                $display("%0t: record with none expected, expected none actual %h",
                         $time, result);
                mismatches++;
            end
            else
            begin
                want = block_q.pop_front();
                compare_field("block_pc", want.block_pc, result.block_pc);
                compare_field("block_len", 32'(want.block_len), 32'(result.block_len));
                compare_field("last_block", 32'(want.last_block), 32'(result.last_block));
                compare_field("overflow", 32'(want.overflow), 32'(result.overflow));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // A drain with nothing fed gives one empty, final block at the start.
    task automatic test_empty_function();
        bit fn_done;
        set_base(32'h0000_0000);
        drain_step(fn_done);
    endtask

    // Every decoded form once: relative and absolute b and bc in both
    // directions, each block ender, opcodes that look like enders but are
    // not, the all-zero and all-one words, and the widest displacements.
    task automatic test_decode();
        set_base(32'h0000_1000);
        feed(branch_to(4, 1'b0, 1'b0));
        feed(branch_to(0, 1'b1, 1'b0));
        feed(branch_to(6, 1'b0, 1'b1));
        feed(branch_to(7, 1'b1, 1'b1));
        for (int k = 0; k < 5; k++)
            feed(block_end_word(k));
        feed({OP_XL, 15'h0000, 10'd17, 1'b0});
        feed({OP_X, 15'h7FFF, 10'd147, 1'b1});
        feed(32'h0000_0000);
        feed(32'hFFFF_FFFF);
        feed({OP_B, 24'h80_0000, 2'b00});
        feed({OP_BC, 10'h3FF, 14'h1FFF, 2'b01});
        drain_to_end();
    endtask

    // A misaligned start address, and words fed after a record has already
    // been read: the drain carries on over the longer function.
    task automatic test_feed_during_drain();
        bit fn_done;
        set_base(32'hFFFF_FFFF);
        feed(plain_word());
        feed(block_end_word(3));
        feed(plain_word());
        drain_step(fn_done);
        feed(branch_to(0, 1'b0, 1'b0));
        feed(plain_word());
        drain_to_end();
    endtask

    // More words than the bitmap holds, at the top of the address space:
    // one block of full length, the extra words dropped, overflow raised.
    task automatic test_capacity();
        set_base(32'hFFFF_FFFC);
        repeat (MAX_INSTS + 6) feed(plain_word());
        drain_to_end();
    endtask

    // One random function of n words, with the odd record read part way
    // through, then drained to its end.
    task automatic run_function(input int unsigned n);
        bit fn_done;
        for (int unsigned i = 0; i < n; i++)
        begin
            if ($urandom_range(19) == 0)
                drain_step(fn_done);
            feed(random_word(n + 4));
        end
        // Now and then the sender waits for the block to go quiet.
        if ($urandom_range(7) == 0)
            wait_drained();
        drain_to_end();
    endtask

    // Random functions in three stretches, each with its own start address:
    // low enough for absolute targets, anywhere at all, and near the top so
    // that addresses wrap.
    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        logic [31:0] start;
        int unsigned goal;
        int unsigned n;
        send_idle = send_pct;
        recv_idle = recv_pct;
        for (int stretch = 0; stretch < 3; stretch++)
        begin
            case (stretch)
                0:       start = $urandom_range(32'h3FFF) << 2;
                1:       start = $urandom;
                default: start = 32'hFFFF_FFFC - ($urandom_range(32'h3FF) << 2);
            endcase
            set_base(start);
            goal = words_sent + 10;
            while (words_sent < goal)
            begin
                // Mostly short functions, now and then a long one.
                if ($urandom_range(15) == 0)
                    n = $urandom_range(200, 60);
                else
                    n = $urandom_range(30, 0);
                run_function(n);
            end
        end
    endtask

    // Stops a hung run.
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 18;
        recv_idle = 72;
        test_empty_function();
        test_decode();
        test_feed_during_drain();
        test_capacity();

        test_random_traffic(18, 72);
        test_random_traffic(72, 18);
        test_random_traffic(0, 0);

        // Let everything come out, then allow for a full drain and clear
        // before looking for records that never arrived.
        wait_drained();
        repeat (3 * MAX_INSTS) @(posedge clk);
        if (block_q.size() != 0)
        begin
            $display("%0t: records left over, expected 0 actual %0d",
                     $time, block_q.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
sv/ppcbb_pkg.sv
sv/ppcbb_ram.sv
sv/ppcbb_alu.sv
sv/ppcbb_seq.sv
sv/ppc_basic_block_leader_scan_top.sv
sv/ppcbb_chk.sv
sim/testbench.sv
